// File: rtl/tdpt_pkg.sv
// shared constants and types for the trial division prime test
`default_nettype none

package tdpt_pkg;

    // width of the candidate field on the input stream
    localparam int CAND_IN_BITS = 32;
    // default datapath width of the candidate
    localparam int CAND_BITS_DEF = 32;
    // output tdata is the flag padded to one byte
    localparam int OUT_DATA_BITS = 8;

    // status from the shared divider to the sequencer
    typedef struct packed {
        logic done;
        logic rem_zero;
        logic quo_ge_div;
    } div_status_t;

endpackage

`default_nettype wire

// File: rtl/tdpt_div.sv
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module tdpt_div #(
    parameter int W = tdpt_pkg::CAND_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [W-1:0]          dividend,
    input  wire logic [W-1:0]          divisor,
    output tdpt_pkg::div_status_t      status
);
    import tdpt_pkg::*;

    localparam int STEP_BITS = $clog2(W + 1);

    logic [W:0]           rem_reg, rem_next;
    logic [W-1:0]         quo_reg, quo_next;
    logic [W-1:0]         div_reg, div_next;
    logic [STEP_BITS-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [W:0] shifted;
    logic       ge;

    always_comb
    begin
        shifted   = {rem_reg[W-1:0], quo_reg[W-1]};
        ge        = shifted >= {1'b0, div_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
            cnt_next  = STEP_BITS'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (shifted - {1'b0, div_reg}) : shifted;
            quo_next = {quo_reg[W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign status.done       = done_reg;
    assign status.rem_zero   = (rem_reg == '0);
    assign status.quo_ge_div = (quo_reg >= div_reg);

endmodule

`default_nettype wire

// File: rtl/trial_division_prime_test_core.sv
// values below 3 and even values are decided in the check state without the divider; an odd
// candidate is divided by each odd divisor from 3 upward in turn on the shared divider,
// which produces one quotient bit per cycle
// throughput: one item at a time, s_axis_tready is high only while idle
// reset: rst_n asynchronous active low, clears the sequencer and the output valid
`default_nettype none

module trial_division_prime_test_core #(
    parameter int CANDIDATE_BITS = tdpt_pkg::CAND_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [tdpt_pkg::CAND_IN_BITS-1:0]   s_axis_tdata,  // [31:0] candidate
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [tdpt_pkg::OUT_DATA_BITS-1:0]       m_axis_tdata   // [0] prime_flag, rest zero
);
    import tdpt_pkg::*;

    localparam int W = CANDIDATE_BITS;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]   state_reg, state_next;
    logic [W-1:0] n_reg, n_next;
    logic [W-1:0] d_reg, d_next;
    logic         flag_reg, flag_next;
    logic         out_valid_reg, out_valid_next;
    logic         out_flag_reg, out_flag_next;
    logic         div_start;
    logic [W-1:0] cand_n;

    div_status_t  div_st;

    tdpt_div #(
        .W(W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (d_reg),
        .status   (div_st)
    );

    // narrow or zero-extend the candidate to the datapath width
    always_comb
    begin
        cand_n = '0;
        for (int i = 0; i < W; i++)
        begin
            if (i < CAND_IN_BITS)
                cand_n[i] = s_axis_tdata[i];
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg;
        out_flag_next  = out_flag_reg;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    n_next     = cand_n;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                d_next = W'(3);
                if (n_reg < W'(2))
                begin
                    flag_next  = 1'b0;
                    state_next = ST_DONE;
                end
                else if (n_reg == W'(2))
                begin
                    flag_next  = 1'b1;
                    state_next = ST_DONE;
                end
                else if (!n_reg[0])
                begin
                    flag_next  = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // the divider start is a pulse on entry and after each step to the next divisor, once d_reg holds it
                if (div_st.done)
                begin
                    if (!div_st.quo_ge_div)
                    begin
                        flag_next  = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (div_st.rem_zero)
                    begin
                        flag_next  = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        d_next = d_reg + W'(2);
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_flag_next  = flag_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // start the divider on entry to the divide state and after each next divisor
    logic div_pending_reg, div_pending_next;

    always_comb
    begin
        div_pending_next = 1'b0;
        if ((state_reg == ST_CHECK) && (state_next == ST_DIV))
            div_pending_next = 1'b1;
        else if ((state_reg == ST_DIV) && div_st.done && (state_next == ST_DIV))
            div_pending_next = 1'b1;
    end

    assign div_start = div_pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            div_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            div_pending_reg <= div_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        d_reg        <= d_next;
        flag_reg     <= flag_next;
        out_flag_reg <= out_flag_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_BITS-1){1'b0}}, out_flag_reg};

endmodule

`default_nettype wire

// File: rtl/tdpt_check.sv
// port-level checks for the prime test core, bound to the top level
`default_nettype none

module tdpt_check (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic [31:0] s_axis_tdata,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);

    // a stalled result item holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    // the core is busy right after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready after accepting an item");

    // an idle core with no offer stays ready
    a_idle_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready && !s_axis_tvalid |=> s_axis_tready)
        else $error("core left idle with no item");

    // padding bits of the result stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
        else $error("result padding not zero");

endmodule

bind trial_division_prime_test_core tdpt_check u_tdpt_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
